/* hdl/hta_pkg.sv */
// shared constants, codes and types for the handle table allocator
`default_nettype none

package hta_pkg;

  localparam int TABLE_DEPTH  = 4096;
  localparam int HANDLE_SPAN  = 4096;
  localparam int USABLE_SLOTS = (TABLE_DEPTH < HANDLE_SPAN) ? TABLE_DEPTH : HANDLE_SPAN;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 12;
  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;

  localparam int ROW_BITS  = 64;
  localparam int BIT_W     = 6;
  localparam int ROW_COUNT = (USABLE_SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SLOT_W    = $clog2(USABLE_SLOTS);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic load_item;
    logic row_rd;
    logic eval;
    logic write;
    logic out_load;
  } hta_cmd_t;

endpackage

`default_nettype wire

/* hdl/hta_ctrl.sv */
// sequencing state machine and output valid for the handle table allocator
`default_nettype none

module hta_ctrl
  import hta_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output hta_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled beat");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |=> !cmd_o.write)
    else $error("table written twice for one item");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_ROW))
    else $error("accepted beat did not start processing");

endmodule

`default_nettype wire

/* hdl/hta_dp.sv */
// bitmap and payload memories, free slot search and result registers
`default_nettype none

module hta_dp
  import hta_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hta_cmd_t            cmd_i,
  input  wire logic [OP_W-1:0]     opcode_i,
  input  wire logic [HANDLE_W-1:0] handle_in_i,
  input  wire logic [VALUE_W-1:0]  store_value_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [HANDLE_W-1:0]      handle_out_o,
  output logic [VALUE_W-1:0]       value_out_o
);

  function automatic logic [ROW_BITS-1:0] row_fixed_mask(input logic [ROW_W-1:0] row);
    logic [ROW_BITS-1:0] m;
    int unsigned         slot;
    m = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      slot = int'(row) * ROW_BITS + b;
      m[b] = (slot == 0) || (slot >= USABLE_SLOTS);
    end
    return m;
  endfunction

  logic [ROW_BITS-1:0] bm_mem [ROW_COUNT];
  logic [VALUE_W-1:0]  vm_mem [USABLE_SLOTS];

  logic [ROW_COUNT-1:0] touched_q;
  logic [ROW_COUNT-1:0] full_q;

  logic [OP_W-1:0]     op_q;
  logic [HANDLE_W-1:0] hnd_q;
  logic [VALUE_W-1:0]  val_q;

  logic [ROW_W-1:0]    row_q, row_d;
  logic                nofree_q, nofree_d;
  logic [ROW_BITS-1:0] bm_rd_q;
  logic [VALUE_W-1:0]  vm_rd_q;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [VALUE_W-1:0]  res_value_q, res_value_d;
  logic [ROW_BITS-1:0] new_word_q, new_word_d;
  logic                wr_bm_q, wr_bm_d;
  logic                wr_vm_q, wr_vm_d;

  logic [STATUS_W-1:0] out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [VALUE_W-1:0]  out_value_q;

  logic                in_range_i;
  logic [HANDLE_W-1:0] hnd_row_wide;
  logic [ROW_BITS-1:0] word;
  logic [BIT_W-1:0]    zidx;
  logic                zfound;
  logic                in_range_q;
  logic                live;
  logic [BIT_W-1:0]    hbit;
  logic [HANDLE_W-1:0] slot_num;

  // row select: lowest non-full row on allocate, handle row otherwise
  assign in_range_i   = 32'(handle_in_i) < USABLE_SLOTS;
  assign hnd_row_wide = hnd_q >> BIT_W;

  always_comb begin
    row_d    = '0;
    nofree_d = 1'b1;
    if (op_q == OP_ALLOC) begin
      for (int r = ROW_COUNT - 1; r >= 0; r--) begin
        if (!full_q[r]) begin
          row_d    = ROW_W'(r);
          nofree_d = 1'b0;
        end
      end
    end else begin
      nofree_d = 1'b0;
      if (in_range_q) begin
        row_d = hnd_row_wide[ROW_W-1:0];
      end
    end
  end

  // evaluation on the registered row word
  assign word     = (touched_q[row_q] ? bm_rd_q : '0) | row_fixed_mask(row_q);
  assign hbit     = hnd_q[BIT_W-1:0];
  assign live     = in_range_q && (hnd_q != '0) && word[hbit];
  assign slot_num = (HANDLE_W'(row_q) << BIT_W) | HANDLE_W'(zidx);

  always_comb begin
    zidx   = '0;
    zfound = 1'b0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        zidx   = BIT_W'(b);
        zfound = 1'b1;
      end
    end
  end

  always_comb begin
    res_status_d = ST_INVALID;
    res_handle_d = '0;
    res_value_d  = '0;
    new_word_d   = word;
    wr_bm_d      = 1'b0;
    wr_vm_d      = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        if (!nofree_q && zfound) begin
          res_status_d     = ST_OK;
          res_handle_d     = slot_num;
          new_word_d[zidx] = 1'b1;
          wr_bm_d          = 1'b1;
          wr_vm_d          = 1'b1;
        end else begin
          res_status_d = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (live) begin
          res_status_d = ST_OK;
          res_value_d  = vm_rd_q;
        end
      end
      OP_RELEASE: begin
        if (live) begin
          res_status_d     = ST_OK;
          new_word_d[hbit] = 1'b0;
          wr_bm_d          = 1'b1;
        end
      end
      default: begin
        res_status_d = ST_INVALID;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_rd) begin
      bm_rd_q <= bm_mem[row_d];
      vm_rd_q <= vm_mem[hnd_q[SLOT_W-1:0]];
    end
    if (cmd_i.write && wr_bm_q) begin
      bm_mem[row_q] <= new_word_q;
    end
    if (cmd_i.write && wr_vm_q) begin
      vm_mem[res_handle_q[SLOT_W-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= '0;
      full_q    <= '0;
      wr_bm_q   <= 1'b0;
      wr_vm_q   <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        wr_bm_q <= wr_bm_d;
        wr_vm_q <= wr_vm_d;
      end
      if (cmd_i.write && wr_bm_q) begin
        touched_q[row_q] <= 1'b1;
        full_q[row_q]    <= &new_word_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= opcode_i;
      hnd_q      <= handle_in_i;
      val_q      <= store_value_i;
      in_range_q <= in_range_i;
    end
    if (cmd_i.row_rd) begin
      row_q    <= row_d;
      nofree_q <= nofree_d;
    end
    if (cmd_i.eval) begin
      res_status_q <= res_status_d;
      res_handle_q <= res_handle_d;
      res_value_q  <= res_value_d;
      new_word_q   <= new_word_d;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_value_q  <= res_value_q;
    end
  end

  assign status_o     = out_status_q;
  assign handle_out_o = out_handle_q;
  assign value_out_o  = out_value_q;

  a_fail_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && res_status_q != ST_OK) |-> (res_handle_q == '0 && res_value_q == '0))
    else $error("failed operation carries a handle or payload");

  a_no_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && wr_vm_q) |-> (res_handle_q != '0 && res_status_q == ST_OK))
    else $error("slot zero granted or payload written without success");

  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write && wr_bm_q) |=> touched_q[row_q])
    else $error("written bitmap row not marked as touched");

endmodule

`default_nettype wire

/* hdl/handle_table_allocator.sv */
// top level of the handle table allocator
// Each beat carries one operation (allocate, look up or release) and yields exactly one
// result beat. The steps from acceptance to a loaded result are: accept, row
// select with bitmap and payload memory read, evaluation with a lowest-free-bit search,
// and table write with result load. The bitmap memory holds 64-bit rows. No new item is
// taken until a result is loaded; a stalled result waits in a hold state. Allocate
// picks the lowest non-full row from a per-row full flag, then the lowest free bit in
// that row, so handles start at 1. Per-row touched flags cleared at reset make unwritten
// rows read as free, so the block is ready straight after reset with no clearing pass.
`default_nettype none

module handle_table_allocator
  import hta_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     opcode_i,
  input  wire logic [HANDLE_W-1:0] handle_in_i,
  input  wire logic [VALUE_W-1:0]  store_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [HANDLE_W-1:0]      handle_out_o,
  output logic [VALUE_W-1:0]       value_out_o
);

  hta_cmd_t cmd;

  hta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  hta_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .handle_in_i   (handle_in_i),
    .store_value_i (store_value_i),
    .status_o      (status_o),
    .handle_out_o  (handle_out_o),
    .value_out_o   (value_out_o)
  );

endmodule

`default_nettype wire
